### hw/rtl/max_pool_2d_argmax_unit_defines.svh
// Assertion macros shared by the max pooling checker.
`ifndef MAX_POOL_2D_ARGMAX_UNIT_DEFINES_SVH
`define MAX_POOL_2D_ARGMAX_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, quiet while arst_n is low.
`define MPA_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, quiet while arst_n is low.
`define MPA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/mpa_pkg.sv
// Shared constants, register codes and helpers of the max pooling unit.
package mpa_pkg;

	localparam int CFG_ADDR_BITS = 3;
	localparam int CFG_DATA_BITS = 9;
	localparam int INDEX_BITS    = 24;

	typedef enum logic [CFG_ADDR_BITS-1:0] {
		REG_POOL_SIZE   = 3'd0,
		REG_STRIDE      = 3'd1,
		REG_IN_HEIGHT   = 3'd2,
		REG_IN_WIDTH    = 3'd3,
		REG_IN_CHANNELS = 3'd4
	} cfg_reg_t;

	localparam logic [2:0] RST_POOL_SIZE   = 3'd2;
	localparam logic [2:0] RST_STRIDE      = 3'd2;
	localparam logic [8:0] RST_IN_HEIGHT   = 9'd28;
	localparam logic [8:0] RST_IN_WIDTH    = 9'd28;
	localparam logic [8:0] RST_IN_CHANNELS = 9'd1;

	function automatic int max2(input int a, input int b);
		return (a > b) ? a : b;
	endfunction

endpackage

### hw/rtl/mpa_out_fifo.sv
// Small result queue that decouples the pooling pipeline from the output stream.
module mpa_out_fifo #(
	parameter int WIDTH = 42,
	parameter int DEPTH = 3
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	input  logic [WIDTH-1:0]             push_data,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [WIDTH-1:0]             out_data,
	output logic [$clog2(DEPTH+1)-1:0]   count
);
	localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNTW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] store_q [DEPTH];
	logic [PTRW-1:0]  rd_ptr_q, wr_ptr_q;
	logic [CNTW-1:0]  cnt_q;
	logic             pop;

	assign out_valid = (cnt_q != '0);
	assign out_data  = store_q[rd_ptr_q];
	assign pop       = out_valid & out_ready;
	assign count     = cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			store_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTRW'(DEPTH - 1)) ? '0 : wr_ptr_q + PTRW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTRW'(DEPTH - 1)) ? '0 : rd_ptr_q + PTRW'(1);
			end
			cnt_q <= cnt_q + CNTW'(push) - CNTW'(pop);
		end
	end

endmodule

### hw/rtl/max_pool_2d_argmax_unit.sv
// Top level of the 2-D max pooling unit with argmax, streaming samples in raster order.
// Results pass the write-back stage and output queue to m_axis; the column store does one read
// and one write a cycle. Throughput: one sample beat per cycle while s_axis_tready is high.
// Back-to-back hits on one column entry are forwarded from the write-back stage.
// Reset: arst_n clears positions, pipeline and queue and restores register defaults;
// the column store needs no clearing as every entry is written before it is read.
module max_pool_2d_argmax_unit #(
	parameter int MAX_WIDTH    = 256,
	parameter int MAX_HEIGHT   = 256,
	parameter int MAX_CHANNELS = 256,
	parameter int MAX_POOL     = 4,
	parameter int SAMPLE_BITS  = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic [mpa_pkg::CFG_ADDR_BITS-1:0]      cfg_addr,
	input  logic [mpa_pkg::CFG_DATA_BITS-1:0]      cfg_wdata,
	input  logic                                   s_axis_tvalid,
	output logic                                   s_axis_tready,
	// sample
	input  logic [((SAMPLE_BITS+7)/8)*8-1:0]       s_axis_tdata,
	output logic                                   m_axis_tvalid,
	input  logic                                   m_axis_tready,
	// max_value, max_index
	output logic [((SAMPLE_BITS+mpa_pkg::INDEX_BITS+7)/8)*8-1:0] m_axis_tdata,
	// channel_done
	output logic [0:0]                             m_axis_tuser,
	output logic                                   m_axis_tlast
);
	import mpa_pkg::*;

	localparam int XW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int YW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int CHW   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int NW    = max2(max2($clog2(MAX_WIDTH + 1), $clog2(MAX_HEIGHT + 1)),
		max2($clog2(MAX_CHANNELS + 1), CFG_DATA_BITS)) + 1;
	localparam int SLW   = (MAX_POOL > 1) ? $clog2(MAX_POOL) : 1;
	localparam int HISTD = (MAX_POOL > 1) ? MAX_POOL - 1 : 1;
	localparam int CANDW = SAMPLE_BITS + INDEX_BITS;
	localparam int WORDW = MAX_POOL * CANDW;
	localparam int OUT_BITS = ((SAMPLE_BITS + INDEX_BITS + 7) / 8) * 8;
	localparam int FIFO_DEPTH = 3;
	localparam int FCW   = $clog2(FIFO_DEPTH + 1);

	// ---------------------------------------------------------------- registers
	logic [2:0] pool_q, stride_q;
	logic [8:0] height_q, width_q, chans_q;
	logic       cfg_hit;

	always_comb begin
		case (cfg_addr)
			REG_POOL_SIZE, REG_STRIDE, REG_IN_HEIGHT, REG_IN_WIDTH, REG_IN_CHANNELS:
				cfg_hit = cfg_we;
			default: cfg_hit = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_q   <= RST_POOL_SIZE;
			stride_q <= RST_STRIDE;
			height_q <= RST_IN_HEIGHT;
			width_q  <= RST_IN_WIDTH;
			chans_q  <= RST_IN_CHANNELS;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_POOL_SIZE:   pool_q   <= cfg_wdata[2:0];
				REG_STRIDE:      stride_q <= cfg_wdata[2:0];
				REG_IN_HEIGHT:   height_q <= cfg_wdata;
				REG_IN_WIDTH:    width_q  <= cfg_wdata;
				REG_IN_CHANNELS: chans_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Effective geometry: zero acts as one, oversize values saturate (stride is taken as is).
	logic [NW-1:0] pool_x, height_x, width_x, chans_x;
	logic [NW-1:0] p_e, s_e, h_e, w_e, c_e;
	logic          en;

	always_comb begin
		pool_x   = NW'(pool_q);
		height_x = NW'(height_q);
		width_x  = NW'(width_q);
		chans_x  = NW'(chans_q);
		p_e = (pool_x == '0) ? NW'(1) :
			((pool_x > NW'(MAX_POOL)) ? NW'(MAX_POOL) : pool_x);
		s_e = (stride_q == '0) ? NW'(1) : NW'(stride_q);
		h_e = (height_x == '0) ? NW'(1) :
			((height_x > NW'(MAX_HEIGHT)) ? NW'(MAX_HEIGHT) : height_x);
		w_e = (width_x == '0) ? NW'(1) :
			((width_x > NW'(MAX_WIDTH)) ? NW'(MAX_WIDTH) : width_x);
		c_e = (chans_x == '0) ? NW'(1) :
			((chans_x > NW'(MAX_CHANNELS)) ? NW'(MAX_CHANNELS) : chans_x);
		// no windows at all when the channel is smaller than the window
		en = (w_e >= p_e) && (h_e >= p_e);
	end

	// ---------------------------------------------------------------- positions
	logic [XW-1:0]         col_q, xi_q;
	logic [YW-1:0]         row_q;
	logic [CHW-1:0]        chan_q;
	logic [INDEX_BITS-1:0] flat_q;
	logic [2:0]            phx_q, phy_q;     // column and row phase modulo stride
	logic [SLW-1:0]        xsl_q, ysl_q;     // window slot modulo pool size
	// Starts of the last few columns and rows: k columns (j rows) back
	logic                  hv_q [HISTD];
	logic [XW-1:0]         hx_q [HISTD];
	logic [SLW-1:0]        hs_q [HISTD];
	logic                  vv_q [HISTD];
	logic [SLW-1:0]        vs_q [HISTD];

	logic                   acc;
	logic [SAMPLE_BITS-1:0] sample;
	logic [NW-1:0]          col_x, row_x, chan_x;
	logic                   last_col, last_row, last_chan;
	logic                   start_now, start_row;

	assign acc    = s_axis_tvalid & s_axis_tready;
	assign sample = s_axis_tdata[SAMPLE_BITS-1:0];

	always_comb begin
		col_x     = NW'(col_q);
		row_x     = NW'(row_q);
		chan_x    = NW'(chan_q);
		last_col  = (col_x + NW'(1) >= w_e);
		last_row  = (row_x + NW'(1) >= h_e);
		last_chan = (chan_x + NW'(1) >= c_e);
		start_now = en && (phx_q == '0) && (col_x + p_e <= w_e);
		start_row = en && (phy_q == '0) && (row_x + p_e <= h_e);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			chan_q <= '0;
			flat_q <= '0;
			phx_q  <= '0;
			phy_q  <= '0;
			xi_q   <= '0;
			xsl_q  <= '0;
			ysl_q  <= '0;
			for (int i = 0; i < HISTD; i++) begin
				hv_q[i] <= 1'b0;
				hx_q[i] <= '0;
				hs_q[i] <= '0;
				vv_q[i] <= 1'b0;
				vs_q[i] <= '0;
			end
		end else if (cfg_hit) begin
			// a write to any defined register restarts the frame
			col_q  <= '0;
			row_q  <= '0;
			chan_q <= '0;
			flat_q <= '0;
			phx_q  <= '0;
			phy_q  <= '0;
			xi_q   <= '0;
			xsl_q  <= '0;
			ysl_q  <= '0;
			for (int i = 0; i < HISTD; i++) begin
				hv_q[i] <= 1'b0;
				vv_q[i] <= 1'b0;
			end
		end else if (acc) begin
			// wrap the flat index at the end of the frame
			flat_q <= (last_col && last_row && last_chan) ? '0 : flat_q + INDEX_BITS'(1);
			if (last_col) begin
				// new row: drop the column history
				col_q <= '0;
				phx_q <= '0;
				xi_q  <= '0;
				xsl_q <= '0;
				for (int i = 0; i < HISTD; i++) begin
					hv_q[i] <= 1'b0;
				end
				if (last_row) begin
					row_q <= '0;
					phy_q <= '0;
					ysl_q <= '0;
					for (int i = 0; i < HISTD; i++) begin
						vv_q[i] <= 1'b0;
					end
					if (last_chan) begin
						chan_q <= '0;
					end else begin
						chan_q <= chan_q + CHW'(1);
					end
				end else begin
					row_q <= row_q + YW'(1);
					phy_q <= (NW'(phy_q) + NW'(1) >= s_e) ? '0 : phy_q + 3'd1;
					if (start_row) begin
						ysl_q <= (NW'(ysl_q) + NW'(1) >= p_e) ? '0 : ysl_q + SLW'(1);
					end
					vv_q[0] <= start_row;
					vs_q[0] <= ysl_q;
					for (int i = 1; i < HISTD; i++) begin
						vv_q[i] <= vv_q[i-1];
						vs_q[i] <= vs_q[i-1];
					end
				end
			end else begin
				col_q <= col_q + XW'(1);
				phx_q <= (NW'(phx_q) + NW'(1) >= s_e) ? '0 : phx_q + 3'd1;
				if (start_now) begin
					xi_q  <= xi_q + XW'(1);
					xsl_q <= (NW'(xsl_q) + NW'(1) >= p_e) ? '0 : xsl_q + SLW'(1);
				end
				hv_q[0] <= start_now;
				hx_q[0] <= xi_q;
				hs_q[0] <= xsl_q;
				for (int i = 1; i < HISTD; i++) begin
					hv_q[i] <= hv_q[i-1];
					hx_q[i] <= hx_q[i-1];
					hs_q[i] <= hs_q[i-1];
				end
			end
		end
	end

	// ---------------------------------------------------------------- row partials
	// Offset k = 0 is the window starting at this very column.
	logic                   hv_c [MAX_POOL];
	logic [XW-1:0]          hx_c [MAX_POOL];
	logic [SLW-1:0]         hs_c [MAX_POOL];
	logic                   vv_c [MAX_POOL];
	logic [SLW-1:0]         vs_c [MAX_POOL];
	logic [SAMPLE_BITS-1:0] rp_val_q [MAX_POOL];
	logic [INDEX_BITS-1:0]  rp_idx_q [MAX_POOL];
	logic [SAMPLE_BITS-1:0] rp_val_n [MAX_POOL];
	logic [INDEX_BITS-1:0]  rp_idx_n [MAX_POOL];
	logic [SLW-1:0]         kc;

	assign kc = SLW'(p_e - NW'(1));

	always_comb begin
		hv_c[0] = start_now;
		hx_c[0] = xi_q;
		hs_c[0] = xsl_q;
		vv_c[0] = start_row;
		vs_c[0] = ysl_q;
		for (int k = 1; k < MAX_POOL; k++) begin
			hv_c[k] = hv_q[k-1];
			hx_c[k] = hx_q[k-1];
			hs_c[k] = hs_q[k-1];
			vv_c[k] = vv_q[k-1];
			vs_c[k] = vs_q[k-1];
		end
	end

	always_comb begin
		for (int q = 0; q < MAX_POOL; q++) begin
			rp_val_n[q] = rp_val_q[q];
			rp_idx_n[q] = rp_idx_q[q];
			for (int k = 0; k < MAX_POOL; k++) begin
				if (hv_c[k] && (NW'(k) < p_e) && (hs_c[k] == SLW'(q))) begin
					// strict compare keeps the earliest maximum
					if (k == 0 || $signed(sample) > $signed(rp_val_q[q])) begin
						rp_val_n[q] = sample;
						rp_idx_n[q] = flat_q;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			for (int q = 0; q < MAX_POOL; q++) begin
				rp_val_q[q] <= rp_val_n[q];
				rp_idx_q[q] <= rp_idx_n[q];
			end
		end
	end

	// Horizontal run of a window closes on this beat.
	logic                   done_h;
	logic [XW-1:0]          xi_c;
	logic [SAMPLE_BITS-1:0] cand_val;
	logic [INDEX_BITS-1:0]  cand_idx;
	logic [MAX_POOL-1:0]    vact, vfirst;
	logic                   emit_v, cd_c, fd_c;
	logic [SLW-1:0]         eslot;

	always_comb begin
		done_h   = acc && hv_c[kc];
		xi_c     = hx_c[kc];
		cand_val = rp_val_n[hs_c[kc]];
		cand_idx = rp_idx_n[hs_c[kc]];
		for (int q = 0; q < MAX_POOL; q++) begin
			vact[q]   = 1'b0;
			vfirst[q] = 1'b0;
			for (int j = 0; j < MAX_POOL; j++) begin
				if (vv_c[j] && (NW'(j) < p_e) && (vs_c[j] == SLW'(q))) begin
					vact[q] = 1'b1;
					if (j == 0) begin
						vfirst[q] = 1'b1;
					end
				end
			end
		end
		emit_v = vv_c[kc];
		eslot  = vs_c[kc];
		// last window of the row and of the column: no later start still fits
		cd_c = (col_x + s_e + NW'(1) > w_e) && (row_x + s_e + NW'(1) > h_e);
		fd_c = cd_c && last_chan;
	end

	// ---------------------------------------------------------------- column store
	// One word per window column: a candidate for each of the row slots.
	logic [WORDW-1:0]       colmem [MAX_WIDTH];
	logic [WORDW-1:0]       rd_q, fwd_q, base, wword;
	logic                   v_s1, emit_s1, cd_s1, fd_s1, fwd_s1;
	logic [XW-1:0]          addr_s1;
	logic [SAMPLE_BITS-1:0] cand_val_s1;
	logic [INDEX_BITS-1:0]  cand_idx_s1;
	logic [MAX_POOL-1:0]    vact_s1, vfirst_s1;
	logic [SLW-1:0]         eslot_s1;
	logic [CANDW-1:0]       res_word;

	always_ff @(posedge clk) begin
		if (done_h) begin
			rd_q <= colmem[xi_c];
		end
		if (v_s1) begin
			colmem[addr_s1] <= wword;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= done_h;
		end
	end

	always_ff @(posedge clk) begin
		if (done_h) begin
			addr_s1     <= xi_c;
			cand_val_s1 <= cand_val;
			cand_idx_s1 <= cand_idx;
			vact_s1     <= vact;
			vfirst_s1   <= vfirst;
			emit_s1     <= emit_v;
			eslot_s1    <= eslot;
			cd_s1       <= cd_c;
			fd_s1       <= fd_c;
			// the read misses the write of the same edge: take it from here
			fwd_s1      <= v_s1 && (addr_s1 == xi_c);
			fwd_q       <= wword;
		end
	end

	always_comb begin
		base  = fwd_s1 ? fwd_q : rd_q;
		wword = base;
		for (int q = 0; q < MAX_POOL; q++) begin
			if (vact_s1[q] && (vfirst_s1[q] ||
				$signed(cand_val_s1) > $signed(base[q*CANDW +: SAMPLE_BITS]))) begin
				wword[q*CANDW +: CANDW] = {cand_idx_s1, cand_val_s1};
			end
		end
		res_word = wword[eslot_s1*CANDW +: CANDW];
	end

	// ---------------------------------------------------------------- output
	logic                 push;
	logic [CANDW+1:0]     push_data, out_data;
	logic [FCW-1:0]       occ;

	assign push      = v_s1 && emit_s1;
	assign push_data = {fd_s1, cd_s1, res_word};
	// Hold input while queued plus in-flight results could overrun the queue.
	assign s_axis_tready = ((FCW+1)'(occ) + (FCW+1)'(push)) < (FCW+1)'(FIFO_DEPTH);

	mpa_out_fifo #(
		.WIDTH (CANDW + 2),
		.DEPTH (FIFO_DEPTH)
	) u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (out_data),
		.count     (occ)
	);

	assign m_axis_tdata = OUT_BITS'(out_data[CANDW-1:0]);
	assign m_axis_tuser = out_data[CANDW];
	assign m_axis_tlast = out_data[CANDW+1];

endmodule

### hw/rtl/mpa_checker.sv
// Port-level checks of the max pooling unit, bound to its top level.
`include "max_pool_2d_argmax_unit_defines.svh"

module mpa_checker #(
	parameter int SAMPLE_BITS = 16
) (
	input logic                                   clk,
	input logic                                   arst_n,
	input logic                                   s_axis_tvalid,
	input logic                                   s_axis_tready,
	input logic                                   m_axis_tvalid,
	input logic                                   m_axis_tready,
	input logic [((SAMPLE_BITS+mpa_pkg::INDEX_BITS+7)/8)*8-1:0] m_axis_tdata,
	input logic [0:0]                             m_axis_tuser,
	input logic                                   m_axis_tlast
);
	import mpa_pkg::*;

	// Beats in minus results out; a result always follows its own input beat.
	logic [39:0] credit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			credit_q <= '0;
		end else begin
			credit_q <= credit_q + 40'(s_axis_tvalid & s_axis_tready)
				- 40'(m_axis_tvalid & m_axis_tready);
		end
	end

	`MPA_ASSERT_IMPL(a_frame_ends_channel, m_axis_tvalid, !m_axis_tlast || m_axis_tuser[0],
		"frame end without channel end")
	`MPA_ASSERT_IMPL(a_no_spurious, m_axis_tvalid && m_axis_tready, credit_q != '0,
		"result without a sample beat")
	`MPA_ASSERT_IMPL(a_stall_from_output, !s_axis_tready, m_axis_tvalid,
		"input held while no result is waiting")
	`MPA_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast),
		"stalled result changed")

endmodule

bind max_pool_2d_argmax_unit mpa_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_mpa_checker (.*);

### verif/max_pool_2d_argmax_unit_test.sv
// Self-checking testbench of the streaming max pooling unit with argmax.
`timescale 1ns / 100ps

module max_pool_2d_argmax_unit_test;
	import mpa_pkg::*;

	localparam int MAX_WIDTH = 256;
	localparam int MAX_HEIGHT = 256;
	localparam int MAX_CHANNELS = 256;
	localparam int MAX_POOL = 4;
	// register index outside the defined set; the block must ignore it
	localparam logic [CFG_ADDR_BITS-1:0] REG_UNUSED = 3'd5;

	typedef struct {
		logic signed [15:0] max_value;
		logic [23:0] max_index;
		logic channel_done;
		logic frame_done;
	} window_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_ADDR_BITS-1:0] cfg_addr;
	logic [CFG_DATA_BITS-1:0] cfg_wdata;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [15:0] s_axis_tdata;   // sample
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [39:0] m_axis_tdata;   // max_value, max_index
	logic [0:0] m_axis_tuser;    // channel_done
	logic m_axis_tlast;          // frame_done

	max_pool_2d_argmax_unit i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast)
	);

	// Register copies and position state of the pooling predictor
	logic [2:0] pool_reg, stride_reg;
	logic [8:0] height_reg, width_reg, chan_reg;
	int col_at, row_at, chan_at;
	logic [23:0] flat_at;
	logic signed [15:0] row_max_val[MAX_POOL];
	logic [23:0] row_max_idx[MAX_POOL];
	logic signed [15:0] col_max_val[MAX_POOL*MAX_WIDTH];
	logic [23:0] col_max_idx[MAX_POOL*MAX_WIDTH];

	logic [15:0] samples_to_send[$];
	window_t windows_due[$];
	int mismatches = 0;
	bit sample_taken = 0;

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("simulation failed");
		$finish;
	end

	function automatic int clamp_reg(input int v, input int hi);
		if (v == 0) return 1;
		return (v > hi) ? hi : v;
	endfunction

	function automatic void restart_frame();
		col_at = 0;
		row_at = 0;
		chan_at = 0;
		flat_at = '0;
	endfunction

	// Advance the predictor by one sample; queue the window it closes, if any
	function automatic void pool_sample(input logic signed [15:0] v);
		int p, s, h, w, c, xs, xi, hs, ys, yi, slot;
		window_t r;
		p = clamp_reg(pool_reg, MAX_POOL);
		s = (stride_reg == 0) ? 1 : stride_reg;
		h = clamp_reg(height_reg, MAX_HEIGHT);
		w = clamp_reg(width_reg, MAX_WIDTH);
		c = clamp_reg(chan_reg, MAX_CHANNELS);
		if (w >= p && h >= p) begin
			for (int k = 0; k < p && k <= col_at; k++) begin
				xs = col_at - k;
				if (xs % s != 0 || xs + p > w) continue;
				xi = xs / s;
				hs = xi % p;
				if (k == 0 || v > row_max_val[hs]) begin
					row_max_val[hs] = v;
					row_max_idx[hs] = flat_at;
				end
				if (k != p - 1) continue;
				// horizontal run closed: merge down the rows
				for (int j = 0; j < p && j <= row_at; j++) begin
					ys = row_at - j;
					if (ys % s != 0 || ys + p > h) continue;
					yi = ys / s;
					slot = ((yi % p) * MAX_WIDTH + xi) % (MAX_POOL * MAX_WIDTH);
					if (j == 0 || row_max_val[hs] > col_max_val[slot]) begin
						col_max_val[slot] = row_max_val[hs];
						col_max_idx[slot] = row_max_idx[hs];
					end
					if (j == p - 1) begin
						r.max_value = col_max_val[slot];
						r.max_index = col_max_idx[slot];
						r.channel_done = (xi == (w - p) / s) && (yi == (h - p) / s);
						r.frame_done = r.channel_done && (chan_at == c - 1);
						windows_due.push_back(r);
					end
				end
			end
		end
		flat_at = flat_at + 1;
		col_at++;
		if (col_at >= w) begin
			col_at = 0;
			row_at++;
			if (row_at >= h) begin
				row_at = 0;
				chan_at++;
				if (chan_at >= c) restart_frame();
			end
		end
	endfunction

	// Sample side: note accepted beats and predict their windows at the rising edge
	always @(posedge clk) begin
		if (arst_n && s_axis_tvalid && s_axis_tready) begin
			sample_taken = 1;
			pool_sample(s_axis_tdata);
		end
	end

	// Sample driver: one nonblocking update of tvalid per falling edge
	int send_gap = 0;
	int sent_count = 0;
	always @(negedge clk) begin
		logic next_valid;
		next_valid = s_axis_tvalid;
		if (sample_taken) begin
			next_valid = 0;
			sample_taken = 0;
		end
		if (!next_valid && arst_n) begin
			if (send_gap > 0) begin
				send_gap--;
			end else if (samples_to_send.size() > 0) begin
				s_axis_tdata <= samples_to_send.pop_front();
				next_valid = 1;
				sent_count++;
				// alternate bursts with no gaps and stretches of random gaps
				send_gap = ((sent_count / 64) % 3 == 0) ? 0 : $urandom_range(0, 5);
			end
		end
		s_axis_tvalid <= next_valid;
	end

	// Result monitor: compare each beat with the oldest predicted window
	int stall_left = 0;
	int taken_count = 0;
	bit result_taken = 0;
	always @(posedge clk) begin
		window_t exp_w;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			result_taken = 1;
			if (windows_due.size() == 0) begin
				$error("result beat with no window due: data %h", m_axis_tdata);
				mismatches++;
			end else begin
				exp_w = windows_due.pop_front();
				if (m_axis_tdata[15:0] !== exp_w.max_value) begin
					$error("max_value: expected %0d, got %0d", exp_w.max_value,
						$signed(m_axis_tdata[15:0]));
					mismatches++;
				end
				if (m_axis_tdata[39:16] !== exp_w.max_index) begin
					$error("max_index: expected %0d, got %0d", exp_w.max_index,
						m_axis_tdata[39:16]);
					mismatches++;
				end
				if (m_axis_tuser[0] !== exp_w.channel_done) begin
					$error("channel_done: expected %0b, got %0b", exp_w.channel_done,
						m_axis_tuser[0]);
					mismatches++;
				end
				if (m_axis_tlast !== exp_w.frame_done) begin
					$error("frame_done: expected %0b, got %0b", exp_w.frame_done,
						m_axis_tlast);
					mismatches++;
				end
			end
		end
	end

	// Result stall: hold tready low for a drawn number of cycles per beat
	always @(negedge clk) begin
		logic next_ready;
		next_ready = m_axis_tready;
		if (result_taken) begin
			result_taken = 0;
			taken_count++;
			stall_left = ((taken_count / 40) % 3 == 1) ? 0 : $urandom_range(0, 5);
		end
		if (stall_left > 0) begin
			stall_left--;
			next_ready = 0;
		end else begin
			next_ready = 1;
		end
		m_axis_tready <= next_ready;
	end

	task automatic write_reg(input logic [CFG_ADDR_BITS-1:0] idx, input int val);
		@(negedge clk);
		cfg_we <= 1;
		cfg_addr <= idx;
		cfg_wdata <= val[8:0];
		case (idx)
			REG_POOL_SIZE: pool_reg = val[2:0];
			REG_STRIDE: stride_reg = val[2:0];
			REG_IN_HEIGHT: height_reg = val[8:0];
			REG_IN_WIDTH: width_reg = val[8:0];
			REG_IN_CHANNELS: chan_reg = val[8:0];
			default: ;
		endcase
		if (idx <= REG_IN_CHANNELS) restart_frame();
		@(negedge clk);
		cfg_we <= 0;
	endtask

	// Hold off until the sample queue is drained and every window has come out
	task automatic wait_idle();
		while (samples_to_send.size() > 0 || s_axis_tvalid || windows_due.size() > 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic configure(input int p, input int s, input int h, input int w,
		input int c);
		wait_idle();
		write_reg(REG_POOL_SIZE, p);
		write_reg(REG_STRIDE, s);
		write_reg(REG_IN_HEIGHT, h);
		write_reg(REG_IN_WIDTH, w);
		write_reg(REG_IN_CHANNELS, c);
	endtask

	// Mostly small dimensions, now and then zero, the maximum or above it
	function automatic int pick_dim();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0) return 0;
		if (r == 1) return $urandom_range(257, 511);
		if (r == 2) return 256;
		return $urandom_range(1, 7);
	endfunction

	initial begin
		int total, n, h, w, c;
		cfg_we = 0;
		cfg_addr = REG_POOL_SIZE;
		cfg_wdata = '0;
		s_axis_tvalid = 0;
		s_axis_tdata = '0;
		m_axis_tready = 0;
		pool_reg = RST_POOL_SIZE;
		stride_reg = RST_STRIDE;
		height_reg = RST_IN_HEIGHT;
		width_reg = RST_IN_WIDTH;
		chan_reg = RST_IN_CHANNELS;
		restart_frame();
		arst_n = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// Reset settings: a few rows of a 28 by 28 channel
		for (int i = 0; i < 60; i++) samples_to_send.push_back(16'($urandom));

		// Overlapping 2x2 windows, two 3x3 channels: extremes and ties
		configure(2, 1, 3, 3, 2);
		samples_to_send = '{16'h7fff, 16'h7fff, 16'h8000, 16'h0000, 16'h7fff, 16'h0005,
			16'hffff, 16'hffff, 16'hffff, 16'h8000, 16'h8000, 16'h8000,
			16'h8000, 16'h8000, 16'h0001, 16'h8000, 16'h0001, 16'h8000};

		// Widest channel, then gapped and degenerate settings
		configure(2, 1, 2, 256, 1);
		for (int i = 0; i < 300; i++) samples_to_send.push_back(16'($urandom));
		configure(1, 7, 8, 9, 2);
		for (int i = 0; i < 60; i++) samples_to_send.push_back(16'($urandom));
		configure(0, 0, 0, 0, 0);
		for (int i = 0; i < 5; i++) samples_to_send.push_back(16'($urandom));
		configure(7, 4, 300, 5, 400);
		for (int i = 0; i < 40; i++) samples_to_send.push_back(16'($urandom));
		configure(3, 2, 5, 5, 1);
		for (int i = 0; i < 10; i++) samples_to_send.push_back(16'($urandom));
		// ignored index leaves the frame position alone
		wait_idle();
		write_reg(REG_UNUSED, 9'h1ff);
		for (int i = 0; i < 30; i++) samples_to_send.push_back(16'($urandom));

		// random settings fill the run up to its sample budget
		total = sent_count + samples_to_send.size();
		while (total < 700) begin
			h = pick_dim();
			w = pick_dim();
			c = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 511) : $urandom_range(1, 3);
			configure($urandom_range(0, 7), $urandom_range(0, 7), h, w, c);
			n = $urandom_range(10, 40);
			for (int i = 0; i < n; i++) begin
				// plenty of ties from a narrow range, else full-range samples
				if ($urandom_range(0, 3) == 0)
					samples_to_send.push_back(16'($signed($urandom_range(0, 6)) - 3));
				else
					samples_to_send.push_back(16'($urandom));
			end
			total += n;
		end

		wait_idle();
		repeat (20) @(posedge clk);
		if (mismatches == 0 && windows_due.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/mpa_pkg.sv
hw/rtl/mpa_out_fifo.sv
hw/rtl/max_pool_2d_argmax_unit.sv
hw/rtl/mpa_checker.sv
verif/max_pool_2d_argmax_unit_test.sv
